>>> design/clc_pkg.sv
// ----------------------------------------------------------------------------
// clc_pkg
// Shared types and constants for the card number Luhn classifier.
// ----------------------------------------------------------------------------
package clc_pkg;

    localparam int MAX_DIGITS_DEF = 19;

    localparam int IN_W          = 64;
    localparam int BCD_DIGITS    = 20;              // 2^64-1 has 20 decimal digits
    localparam int BCD_W         = 4 * BCD_DIGITS;
    localparam int BITS_PER_STEP = 4;               // binary bits shifted in per cycle
    localparam int CONV_STEPS    = IN_W / BITS_PER_STEP;
    localparam int CNT_W         = 5;
    localparam int OUT_TDATA_W   = 16;

    // length / prefix rules
    localparam logic [4:0] LEN_13 = 5'd13;
    localparam logic [4:0] LEN_15 = 5'd15;
    localparam logic [4:0] LEN_16 = 5'd16;
    localparam logic [6:0] PFX_34 = 7'd34;
    localparam logic [6:0] PFX_37 = 7'd37;
    localparam logic [6:0] PFX_51 = 7'd51;
    localparam logic [6:0] PFX_55 = 7'd55;
    localparam logic [6:0] PFX_40 = 7'd40;
    localparam logic [6:0] PFX_49 = 7'd49;

    // brand codes: none, 15-digit 34/37, 16-digit 51..55, 13/16-digit leading 4
    typedef enum logic [1:0] {
        BRAND_NONE = 2'd0,
        BRAND_P3X  = 2'd1,
        BRAND_P5X  = 2'd2,
        BRAND_P4X  = 2'd3
    } brand_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic conv;
        logic shift;
    } bcd_ctl_t;

    typedef struct packed {
        logic clear;
        logic take;
    } acc_ctl_t;

endpackage

>>> design/clc_bcd_conv.sv
// ----------------------------------------------------------------------------
// clc_bcd_conv
// Binary to BCD shift-and-add-3 unit, four bits per cycle; afterwards shifts
// the BCD word right one digit per cycle to present the digits low first.
// ----------------------------------------------------------------------------
module clc_bcd_conv (
    input  logic                      clk,
    input  clc_pkg::bcd_ctl_t         ctl,
    input  logic [clc_pkg::IN_W-1:0]  value,
    output logic [3:0]                digit
);
    import clc_pkg::*;

    logic [BCD_W-1:0] bcd_reg;
    logic [BCD_W-1:0] bcd_next;
    logic [IN_W-1:0]  bin_reg;
    logic [IN_W-1:0]  bin_next;
    logic [BCD_W-1:0] bcd_step;
    logic [IN_W-1:0]  bin_step;

    always_comb
    begin
        bcd_step = bcd_reg;
        bin_step = bin_reg;
        for (int s = 0; s < BITS_PER_STEP; s++)
        begin
            for (int k = 0; k < BCD_DIGITS; k++)
            begin
                if (bcd_step[4*k +: 4] >= 4'd5)
                begin
                    bcd_step[4*k +: 4] = bcd_step[4*k +: 4] + 4'd3;
                end
            end
            bcd_step = {bcd_step[BCD_W-2:0], bin_step[IN_W-1]};
            bin_step = {bin_step[IN_W-2:0], 1'b0};
        end
    end

    always_comb
    begin
        bcd_next = bcd_reg;
        bin_next = bin_reg;
        priority if (ctl.load)
        begin
            bcd_next = '0;
            bin_next = value;
        end
        else if (ctl.conv)
        begin
            bcd_next = bcd_step;
            bin_next = bin_step;
        end
        else if (ctl.shift)
        begin
            bcd_next = {4'd0, bcd_reg[BCD_W-1:4]};
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
        bin_reg <= bin_next;
    end

    assign digit = bcd_reg[3:0];

endmodule

>>> design/clc_luhn_acc.sv
// ----------------------------------------------------------------------------
// clc_luhn_acc
// Takes one decimal digit per cycle, low first: keeps the Luhn sum mod 10,
// the digit count and the two leading digits seen so far.
// ----------------------------------------------------------------------------
module clc_luhn_acc (
    input  logic                       clk,
    input  clc_pkg::acc_ctl_t          ctl,
    input  logic [3:0]                 digit,
    input  logic [clc_pkg::CNT_W-1:0]  idx,
    output logic                       sum_zero,
    output logic [4:0]                 digit_count,
    output logic [6:0]                 leading_pair
);
    import clc_pkg::*;

    logic [3:0] sum_reg;
    logic [3:0] sum_next;
    logic [3:0] prev_reg;
    logic [3:0] prev_next;
    logic [4:0] count_reg;
    logic [4:0] count_next;
    logic [6:0] pair_reg;
    logic [6:0] pair_next;
    logic [3:0] weighted;
    logic [4:0] sum_raw;
    logic [6:0] pair_cand;

    // doubled digit with its two digits summed
    function automatic logic [3:0] luhn_dbl(input logic [3:0] d);
        logic [4:0] t;
        t = {d, 1'b0};
        if (t > 5'd9)
        begin
            t = t - 5'd9;
        end
        return t[3:0];
    endfunction

    always_comb
    begin
        weighted  = idx[0] ? luhn_dbl(digit) : digit;
        sum_raw   = {1'b0, sum_reg} + {1'b0, weighted};
        pair_cand = (idx == '0) ? {3'd0, digit}
                  : ({3'd0, digit} << 3) + ({3'd0, digit} << 1) + {3'd0, prev_reg};

        sum_next   = sum_reg;
        prev_next  = prev_reg;
        count_next = count_reg;
        pair_next  = pair_reg;
        priority if (ctl.clear)
        begin
            sum_next   = 4'd0;
            prev_next  = 4'd0;
            count_next = 5'd1;
            pair_next  = 7'd0;
        end
        else if (ctl.take)
        begin
            sum_next  = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];
            prev_next = digit;
            // highest nonzero digit so far sets length and prefix
            if (digit != 4'd0)
            begin
                count_next = 5'(idx) + 5'd1;
                pair_next  = pair_cand;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        prev_reg  <= prev_next;
        count_reg <= count_next;
        pair_reg  <= pair_next;
    end

    assign sum_zero     = (sum_reg == 4'd0);
    assign digit_count  = count_reg;
    assign leading_pair = pair_reg;

endmodule

>>> design/card_number_luhn_classifier.sv
// ----------------------------------------------------------------------------
// card_number_luhn_classifier
// Luhn mod-10 check, digit count, leading pair and brand of a binary card
// number.
// ----------------------------------------------------------------------------
// One beat in, one beat out. After accept, a number passes the binary to BCD
// unit at four bits a cycle, then MAX_DIGITS digits are fed one at a time into
// the Luhn accumulator, and a final step classifies it; the idle state takes
// the next beat. Only one number is in work at a time; the result sits in an
// output register, so the next number is taken while it waits, and the
// classify step holds only while an earlier result is still waiting. Digits
// above MAX_DIGITS are ignored.
module card_number_luhn_classifier #(
    parameter int MAX_DIGITS = clc_pkg::MAX_DIGITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [clc_pkg::IN_W-1:0]         s_tdata,  // [63:0] card_number
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [1:0] brand, [2] luhn_ok, [7:3] digit_count, [14:8] leading_pair, [15] zero
    output logic [clc_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import clc_pkg::*;

    localparam logic [CNT_W-1:0] LAST_CONV  = CNT_W'(CONV_STEPS - 1);
    localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(MAX_DIGITS - 1);

    state_t                 state_reg;
    state_t                 state_next;
    logic [CNT_W-1:0]       step_reg;
    logic [CNT_W-1:0]       step_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;

    bcd_ctl_t   bcd_ctl;
    acc_ctl_t   acc_ctl;
    logic [3:0] digit;
    logic       sum_zero;
    logic [4:0] digit_count;
    logic [6:0] leading_pair;
    brand_t     brand;
    logic       out_free;

    clc_bcd_conv u_bcd (
        .clk   (clk),
        .ctl   (bcd_ctl),
        .value (s_tdata),
        .digit (digit)
    );

    clc_luhn_acc u_acc (
        .clk          (clk),
        .ctl          (acc_ctl),
        .digit        (digit),
        .idx          (step_reg),
        .sum_zero     (sum_zero),
        .digit_count  (digit_count),
        .leading_pair (leading_pair)
    );

    always_comb
    begin
        brand = BRAND_NONE;
        if (sum_zero)
        begin
            priority if (digit_count == LEN_15 &&
                         (leading_pair == PFX_34 || leading_pair == PFX_37))
            begin
                brand = BRAND_P3X;
            end
            else if (digit_count == LEN_16 &&
                     leading_pair >= PFX_51 && leading_pair <= PFX_55)
            begin
                brand = BRAND_P5X;
            end
            else if ((digit_count == LEN_13 || digit_count == LEN_16) &&
                     leading_pair >= PFX_40 && leading_pair <= PFX_49)
            begin
                brand = BRAND_P4X;
            end
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        bcd_ctl        = '0;
        acc_ctl        = '0;
        s_tready       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    bcd_ctl.load = 1'b1;
                    acc_ctl.clear = 1'b1;
                    step_next    = '0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_ctl.conv = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == LAST_CONV)
                begin
                    step_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                acc_ctl.take  = 1'b1;
                bcd_ctl.shift = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == LAST_DIGIT)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, leading_pair, digit_count, sum_zero, brand};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> design/clc_checker.sv
// ----------------------------------------------------------------------------
// clc_checker
// Port-level checks for the card number Luhn classifier.
// ----------------------------------------------------------------------------
module clc_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [clc_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import clc_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one number at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a number is in work");

    // a brand is only given when the Luhn check passes
    a_brand_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] != BRAND_NONE) |-> m_tdata[2])
        else $error("brand set with Luhn failure");

    // the 15-digit brand agrees with the reported length
    a_brand_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == BRAND_P3X) |-> m_tdata[7:3] == LEN_15)
        else $error("15-digit brand with wrong length");

    // count is at least one and the pair is two decimal digits at most
    a_fields_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:3] != 5'd0) && (m_tdata[14:8] <= 7'd99) && !m_tdata[15])
        else $error("result field out of range");

endmodule

bind card_number_luhn_classifier clc_checker u_clc_checker (.*);
